>>> rtl/pip_pkg.sv
package pip_pkg;

	localparam int MAX_VERTICES_DEF = 16;
	localparam int COORD_W = 16;
	localparam int IDX_W = 4;
	localparam int CNT_W = 5;
	localparam int REL_W = COORD_W + 1;
	localparam int MUL_W = REL_W + 1;
	localparam int PROD_W = 2 * MUL_W;
	localparam int NUM_W = PROD_W + 1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic cmd;
		logic [IDX_W-1:0] vertex_index;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic last_vertex;
	} req_t;

	typedef struct packed {
		logic inside_res;
		logic touched;
	} rsp_t;

endpackage

>>> rtl/point_in_polygon_test.sv
// Ray-casting point-in-polygon test on signed Q12.4 coordinates. A load item
// (cmd 0) writes one vertex into the polygon store; the vertex marked last
// sets the vertex count to its index plus one, and loads to slots at or
// beyond MAX_VERTICES are dropped. A query item (cmd 1) walks the polygon
// edge by edge and returns inside_res and touched; the block stalls its
// input until the result is registered for the output. An edge that needs
// no intercept skips the multiply steps of a sloped edge, and a vertex or
// horizontal edge through the point ends the walk at once. The walk is
// paced by the single registered 18x18 multiplier, which forms the four
// products of each sloped edge in turn, and by the one read port of the
// vertex store. Loads are accepted while a finished result waits on the
// output.
module point_in_polygon_test
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = $clog2(MAX_VERTICES);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD0   = 4'd1;
	localparam logic [3:0] S_FIRST = 4'd2;
	localparam logic [3:0] S_CUR   = 4'd3;
	localparam logic [3:0] S_CLS   = 4'd4;
	localparam logic [3:0] S_M1    = 4'd5;
	localparam logic [3:0] S_M2    = 4'd6;
	localparam logic [3:0] S_M3    = 4'd7;
	localparam logic [3:0] S_M4    = 4'd8;
	localparam logic [3:0] S_NEXT  = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	logic [3:0] state_q;
	logic [CNT_W-1:0] vcount_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] k_q;
	logic signed [COORD_W-1:0] px_q;
	logic signed [COORD_W-1:0] py_q;
	logic signed [REL_W-1:0] first_x_q;
	logic signed [REL_W-1:0] first_y_q;
	logic signed [REL_W-1:0] prev_x_q;
	logic signed [REL_W-1:0] prev_y_q;
	logic signed [REL_W-1:0] cur_x_q;
	logic signed [REL_W-1:0] cur_y_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [NUM_W-1:0] num_q;
	logic gt_q;
	logic par_q;
	logic res_in_q;
	logic res_tc_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic accept;
	logic wr_en;
	logic rd_en;
	logic [AW-1:0] rd_addr;
	logic [CNT_W-1:0] k_inc;
	logic [CNT_W-1:0] n_clamp;
	logic signed [COORD_W-1:0] rd_x;
	logic signed [COORD_W-1:0] rd_y;
	logic signed [REL_W-1:0] rel_x;
	logic signed [REL_W-1:0] rel_y;
	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [NUM_W-1:0] p_ext;
	logic signed [NUM_W-1:0] acc_ext;
	logic signed [MUL_W-1:0] den;
	logic signed [MUL_W-1:0] den_abs;
	logic den_neg;
	logic signed [REL_W-1:0] lo;
	logic signed [REL_W-1:0] hi;
	logic v_hit;
	logic behind;
	logic horiz;
	logic hz_hit;
	logic vert_cross;
	logic slot_free;

	assign accept = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign wr_en = accept && (req.cmd == CMD_LOAD)
		&& (32'(req.vertex_index) < 32'(MAX_VERTICES));
	assign k_inc = CNT_W'(k_q + 1'b1);
	assign n_clamp = (32'(vcount_q) > 32'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_q;

	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_RD0: begin
				rd_en = 1'b1;
			end
			S_FIRST: begin
				rd_en = 1'b1;
				rd_addr = AW'(1);
			end
			S_NEXT: begin
				rd_en = 1'b1;
				rd_addr = AW'(k_inc);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	pip_vstore #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_vstore (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(AW'(req.vertex_index)),
		.wr_x(req.coord_x),
		.wr_y(req.coord_y),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_x(rd_x),
		.rd_y(rd_y)
	);

	assign rel_x = {rd_x[COORD_W-1], rd_x} - {px_q[COORD_W-1], px_q};
	assign rel_y = {rd_y[COORD_W-1], rd_y} - {py_q[COORD_W-1], py_q};

	// edge classification, prev is the start and cur the end of the edge
	assign den = {cur_y_q[REL_W-1], cur_y_q} - {prev_y_q[REL_W-1], prev_y_q};
	assign den_neg = den[MUL_W-1];
	assign den_abs = den_neg ? -den : den;
	assign lo = (prev_x_q < cur_x_q) ? prev_x_q : cur_x_q;
	assign hi = (prev_x_q < cur_x_q) ? cur_x_q : prev_x_q;
	assign v_hit = (prev_x_q == '0) && (prev_y_q == '0);
	assign behind = prev_x_q[REL_W-1] && cur_x_q[REL_W-1];
	assign horiz = (prev_y_q == cur_y_q);
	assign hz_hit = horiz && (prev_y_q == '0) && (prev_x_q[REL_W-1] != cur_x_q[REL_W-1]);
	assign vert_cross = !prev_x_q[REL_W-1]
		&& ((prev_y_q < 0 && cur_y_q > 0) || (cur_y_q < 0 && prev_y_q > 0));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_CLS: begin
				mul_a = {prev_x_q[REL_W-1], prev_x_q};
				mul_b = {cur_y_q[REL_W-1], cur_y_q};
			end
			S_M1: begin
				mul_a = {cur_x_q[REL_W-1], cur_x_q};
				mul_b = {prev_y_q[REL_W-1], prev_y_q};
			end
			S_M2: begin
				mul_a = {lo[REL_W-1], lo};
				mul_b = den_abs;
			end
			S_M3: begin
				mul_a = {hi[REL_W-1], hi};
				mul_b = den_abs;
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	pip_mul u_mul (
		.clk(clk),
		.a(mul_a),
		.b(mul_b),
		.p(mul_p)
	);

	assign p_ext = {mul_p[PROD_W-1], mul_p};
	assign acc_ext = {acc_q[PROD_W-1], acc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vcount_q <= '0;
			rsp_valid_q <= 1'b0;
			par_q <= 1'b0;
			k_q <= '0;
			n_q <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && !((state_q == S_OUT) && slot_free)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.cmd == CMD_LOAD) begin
							if (wr_en && req.last_vertex) begin
								vcount_q <= CNT_W'(req.vertex_index) + 1'b1;
							end
						end else begin
							px_q <= req.coord_x;
							py_q <= req.coord_y;
							n_q <= n_clamp;
							par_q <= 1'b0;
							if (n_clamp == '0) begin
								res_in_q <= 1'b0;
								res_tc_q <= 1'b0;
								state_q <= S_OUT;
							end else begin
								state_q <= S_RD0;
							end
						end
					end
				end
				S_RD0: begin
					state_q <= S_FIRST;
				end
				S_FIRST: begin
					first_x_q <= rel_x;
					first_y_q <= rel_y;
					prev_x_q <= rel_x;
					prev_y_q <= rel_y;
					k_q <= CNT_W'(1);
					if (n_q == CNT_W'(1)) begin
						cur_x_q <= rel_x;
						cur_y_q <= rel_y;
						state_q <= S_CLS;
					end else begin
						state_q <= S_CUR;
					end
				end
				S_CUR: begin
					cur_x_q <= rel_x;
					cur_y_q <= rel_y;
					state_q <= S_CLS;
				end
				S_CLS: begin
					if (v_hit || (!behind && hz_hit)) begin
						res_in_q <= 1'b1;
						res_tc_q <= 1'b1;
						state_q <= S_OUT;
					end else if (behind || horiz || (cur_y_q == '0)) begin
						state_q <= S_NEXT;
					end else if (prev_x_q == cur_x_q) begin
						if (vert_cross) begin
							par_q <= !par_q;
						end
						state_q <= S_NEXT;
					end else begin
						state_q <= S_M1;
					end
				end
				S_M1: begin
					acc_q <= mul_p;
					state_q <= S_M2;
				end
				S_M2: begin
					num_q <= den_neg ? (p_ext - acc_ext) : (acc_ext - p_ext);
					state_q <= S_M3;
				end
				S_M3: begin
					gt_q <= (num_q > p_ext);
					state_q <= S_M4;
				end
				S_M4: begin
					if (!num_q[NUM_W-1] && gt_q && (num_q < p_ext)) begin
						par_q <= !par_q;
					end
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (k_q == n_q) begin
						res_in_q <= par_q;
						res_tc_q <= 1'b0;
						state_q <= S_OUT;
					end else begin
						k_q <= k_inc;
						prev_x_q <= cur_x_q;
						prev_y_q <= cur_y_q;
						if (k_inc == n_q) begin
							cur_x_q <= first_x_q;
							cur_y_q <= first_y_q;
							state_q <= S_CLS;
						end else begin
							state_q <= S_CUR;
						end
					end
				end
				S_OUT: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						rsp_q.inside_res <= res_in_q;
						rsp_q.touched <= res_tc_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

>>> rtl/pip_vstore.sv
module pip_vstore
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	localparam int AW = $clog2(MAX_VERTICES)
) (
	input  logic clk,
	input  logic wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic signed [COORD_W-1:0] wr_x,
	input  logic signed [COORD_W-1:0] wr_y,
	input  logic rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic signed [COORD_W-1:0] rd_x,
	output logic signed [COORD_W-1:0] rd_y
);

	logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
	logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];
	logic signed [COORD_W-1:0] rd_x_q;
	logic signed [COORD_W-1:0] rd_y_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= wr_x;
			mem_y[wr_addr] <= wr_y;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_x_q <= mem_x[rd_addr];
			rd_y_q <= mem_y[rd_addr];
		end
	end

	assign rd_x = rd_x_q;
	assign rd_y = rd_y_q;

endmodule

>>> rtl/pip_mul.sv
module pip_mul
	import pip_pkg::*;
(
	input  logic clk,
	input  logic signed [MUL_W-1:0] a,
	input  logic signed [MUL_W-1:0] b,
	output logic signed [PROD_W-1:0] p
);

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule
